@@ hdl/multi_sine_palette_pixel_unit_macros.svh @@
// Assertion macros for the multi-sine palette pixel unit.
// Used by the top level; no other dependencies.
`ifndef MULTI_SINE_PALETTE_PIXEL_UNIT_MACROS_SVH
`define MULTI_SINE_PALETTE_PIXEL_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define MSP_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("msp: assertion failed");
`define MSP_ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("msp: forbidden condition seen");
`else
`define MSP_ASSERT(label, clk, rst, prop)
`define MSP_ASSERT_NEVER(label, clk, rst, cond)
`endif
`endif

@@ hdl/msp_pkg.sv @@
// Shared types, constants and the sine table function of the pixel unit.
// No dependencies.
package msp_pkg;

   localparam int unsigned PALETTE_DEPTH_DEFAULT    = 32;
   localparam int unsigned SINE_TABLE_DEPTH_DEFAULT = 1024;

   localparam logic [31:0] PI_Q30      = 32'd3373259426;
   localparam logic [30:0] DIV100_MULT = 31'd1374389535;
   localparam int unsigned DIV100_SHIFT = 37;
   localparam logic [24:0] PHASE_RECIP = 25'((64'd1 << 56) / 64'(PI_Q30));

   localparam int unsigned MAG_W   = 26;
   localparam int unsigned FREQ_W  = 16;
   localparam int unsigned WAVE_W  = 16;
   localparam int unsigned COLOR_W = 40;
   localparam int unsigned SLOT_W  = 5;

   localparam int unsigned LANE_STAGES = 9;

   localparam logic MODE_WRITE = 1'b0;
   localparam logic MODE_PIXEL = 1'b1;

   localparam logic [2:0] CSR_FREQ_ONE      = 3'd0;
   localparam logic [2:0] CSR_FREQ_TWO      = 3'd1;
   localparam logic [2:0] CSR_FREQ_THREE    = 3'd2;
   localparam logic [2:0] CSR_STRIP_LENGTH  = 3'd3;
   localparam logic [2:0] CSR_PALETTE_COUNT = 3'd4;

   typedef struct packed {
      logic               valid;
      logic               mode;
      logic [SLOT_W-1:0]  slot;
      logic [COLOR_W-1:0] color;
   } ctl_type;

   // Quarter-wave |sin| entry at the centre of bucket k, Q0.16.
   function automatic logic [WAVE_W-1:0] sine_entry(input int unsigned k,
                                                     input int unsigned log2_depth);
      logic [63:0]        x;
      logic [63:0]        term;
      logic signed [65:0] acc;
      logic [63:0]        q;
      x    = (64'(2 * k + 1) * 64'(PI_Q30)) >> (log2_depth + 2);
      term = x;
      acc  = $signed({2'b00, x});
      for (int n = 1; n <= 7; n++) begin
         term = (term * x) >> 30;
         term = (term * x) >> 30;
         term = term / 64'((2 * n) * (2 * n + 1));
         if (n[0]) begin
            acc = acc - $signed({2'b00, term});
         end else begin
            acc = acc + $signed({2'b00, term});
         end
      end
      if (acc < 0) begin
         acc = '0;
      end
      q = (acc[63:0] + 64'd8192) >> 14;
      return (q > 64'd65535) ? {WAVE_W{1'b1}} : q[WAVE_W-1:0];
   endfunction

endpackage

@@ hdl/msp_wave_lane.sv @@
// One |sin| wave lane: phase product, reduction modulo pi, bucket search and table read.
// Depends on msp_pkg.
module msp_wave_lane #(
   parameter int unsigned SINE_TABLE_DEPTH = msp_pkg::SINE_TABLE_DEPTH_DEFAULT
) (
   input  logic                              clock,
   input  logic [msp_pkg::LANE_STAGES-1:0]   stage_en,
   input  logic [msp_pkg::FREQ_W-1:0]        freq,
   input  logic [msp_pkg::MAG_W-1:0]         mag,
   output logic [msp_pkg::WAVE_W-1:0]        wave
);

   localparam int unsigned LOG2D = $clog2(SINE_TABLE_DEPTH);
   localparam int unsigned KW    = LOG2D + 1;
   localparam int unsigned RW    = LOG2D + 2;
   localparam logic [RW-1:0] RANGE_RECIP =
      RW'((64'd1 << (33 + LOG2D)) / 64'(msp_pkg::PI_Q30));
   localparam logic [33:0] PI_X1 = 34'(msp_pkg::PI_Q30);
   localparam logic [33:0] PI_X2 = PI_X1 << 1;
   localparam logic [33:0] PI_X3 = PI_X1 + PI_X2;

   typedef logic [msp_pkg::WAVE_W-1:0] rom_type [SINE_TABLE_DEPTH];

   function automatic rom_type build_rom();
      rom_type rom;
      for (int k = 0; k < int'(SINE_TABLE_DEPTH); k++) begin
         rom[k] = msp_pkg::sine_entry(k, LOG2D);
      end
      return rom;
   endfunction

   localparam rom_type SINE_ROM = build_rom();

   logic [41:0]       phase_ff, phase_in, phase1_ff;
   logic [24:0]       qest_ff, qest_in;
   logic [33:0]       prod_ff, prod_in, low_ff;
   logic [33:0]       rem0_ff, rem0_in;
   logic [31:0]       resid_ff, resid_in, resid5_ff, resid6_ff;
   logic [KW-1:0]     kest_ff, kest_in, kest6_ff;
   logic [KW+31:0]    kprod_ff, kprod_in, kdiff;
   logic [KW-1:0]     k_ff, k_in;
   logic [LOG2D-1:0]  rom_addr;
   logic [msp_pkg::WAVE_W-1:0] wave_ff;

   always_comb begin
      phase_in = 42'(mag) * 42'(freq);
      qest_in  = 25'((57'(phase_ff[41:10]) * 57'(msp_pkg::PHASE_RECIP)) >> 32);
      prod_in  = 34'(qest_ff) * PI_X1;
      rem0_in  = low_ff - prod_ff;
      priority if (rem0_ff >= PI_X3) begin
         resid_in = 32'(rem0_ff - PI_X3);
      end else if (rem0_ff >= PI_X2) begin
         resid_in = 32'(rem0_ff - PI_X2);
      end else if (rem0_ff >= PI_X1) begin
         resid_in = 32'(rem0_ff - PI_X1);
      end else begin
         resid_in = rem0_ff[31:0];
      end
      kest_in  = KW'((64'(resid_ff) * 64'(RANGE_RECIP)) >> 32);
      kprod_in = (KW + 32)'(kest_ff) * (KW + 32)'(msp_pkg::PI_Q30);
      kdiff    = {resid6_ff, {KW{1'b0}}} - kprod_ff;
      k_in     = kest6_ff + KW'(kdiff >= (KW + 32)'(msp_pkg::PI_Q30));
      rom_addr = k_ff[KW-1] ? ~k_ff[LOG2D-1:0] : k_ff[LOG2D-1:0];
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         phase_ff <= phase_in;
      end
      if (stage_en[1]) begin
         qest_ff   <= qest_in;
         phase1_ff <= phase_ff;
      end
      if (stage_en[2]) begin
         prod_ff <= prod_in;
         low_ff  <= {phase1_ff[19:0], 14'd0};
      end
      if (stage_en[3]) begin
         rem0_ff <= rem0_in;
      end
      if (stage_en[4]) begin
         resid_ff <= resid_in;
      end
      if (stage_en[5]) begin
         kest_ff   <= kest_in;
         resid5_ff <= resid_ff;
      end
      if (stage_en[6]) begin
         kprod_ff  <= kprod_in;
         kest6_ff  <= kest_ff;
         resid6_ff <= resid5_ff;
      end
      if (stage_en[7]) begin
         k_ff <= k_in;
      end
      if (stage_en[8]) begin
         wave_ff <= SINE_ROM[rom_addr];
      end
   end

   assign wave = wave_ff;

endmodule

@@ hdl/msp_round_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, for the palette index.
// Depends on nothing but its parameters.
module msp_round_div #(
   parameter int unsigned QUO_W = 5,
   parameter int unsigned NUM_W = 41,
   parameter int unsigned DEN_W = 35
) (
   input  logic             clock,
   input  logic [QUO_W-1:0] stage_en,
   input  logic [NUM_W-1:0] dividend,
   input  logic [DEN_W-1:0] divisor,
   output logic [QUO_W-1:0] quotient
);

   logic [NUM_W-1:0] rem_ff [QUO_W];
   logic [NUM_W-1:0] rem_in [QUO_W];
   logic [QUO_W-1:0] quo_ff [QUO_W];
   logic [QUO_W-1:0] quo_in [QUO_W];

   for (genvar j = 0; j < QUO_W; j++) begin : g_step
      logic [NUM_W-1:0] src_rem;
      logic [QUO_W-1:0] src_quo;
      logic [NUM_W-1:0] shifted;
      if (j == 0) begin : g_first
         assign src_rem = dividend;
         assign src_quo = '0;
      end else begin : g_next
         assign src_rem = rem_ff[j-1];
         assign src_quo = quo_ff[j-1];
      end
      always_comb begin
         shifted = NUM_W'(divisor) << (QUO_W - 1 - j);
         quo_in[j] = src_quo;
         if (src_rem >= shifted) begin
            rem_in[j] = src_rem - shifted;
            quo_in[j][QUO_W-1-j] = 1'b1;
         end else begin
            rem_in[j] = src_rem;
         end
      end
      always_ff @(posedge clock) begin
         if (stage_en[j]) begin
            rem_ff[j] <= rem_in[j];
            quo_ff[j] <= quo_in[j];
         end
      end
   end

   assign quotient = quo_ff[QUO_W-1];

endmodule

@@ hdl/msp_palette.sv @@
// Palette memory with registered read that forms the result register.
// Depends on msp_pkg.
module msp_palette #(
   parameter int unsigned PALETTE_DEPTH = msp_pkg::PALETTE_DEPTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               advance,
   input  msp_pkg::ctl_type                   ctl,
   input  logic [$clog2(PALETTE_DEPTH)-1:0]   read_index,
   output logic                               result_valid,
   output logic [msp_pkg::COLOR_W-1:0]        result_color
);

   localparam int unsigned AW = $clog2(PALETTE_DEPTH);

   logic [msp_pkg::COLOR_W-1:0] mem [PALETTE_DEPTH];
   logic [msp_pkg::COLOR_W-1:0] rd_ff;
   logic                        valid_ff, valid_in;
   logic                        wr_hit;

   assign wr_hit   = ctl.valid && (ctl.mode == msp_pkg::MODE_WRITE) &&
                     (9'(ctl.slot) < 9'(PALETTE_DEPTH));
   assign valid_in = ctl.valid && (ctl.mode == msp_pkg::MODE_PIXEL);

   always_ff @(posedge clock) begin
      if (advance) begin
         if (wr_hit) begin
            mem[AW'(ctl.slot)] <= ctl.color;
         end
         rd_ff <= mem[read_index];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   assign result_valid = valid_ff;
   assign result_color = rd_ff;

endmodule

@@ hdl/multi_sine_palette_pixel_unit.sv @@
// Multi-sine palette pixel unit: one transaction per cycle while rsp_stall is low,
// pixels and palette writes alike, through a fully pipelined datapath with one palette
// port. Synchronous active-high reset empties the pipeline and restores register
// defaults; palette contents stay undefined until written. Depends on msp_pkg and the
// macros.
`include "multi_sine_palette_pixel_unit_macros.svh"
module multi_sine_palette_pixel_unit #(
   parameter int unsigned PALETTE_DEPTH    = msp_pkg::PALETTE_DEPTH_DEFAULT,
   parameter int unsigned SINE_TABLE_DEPTH = msp_pkg::SINE_TABLE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_mode,
   input  logic [15:0] req_pixel_index,
   input  logic [31:0] req_time_ms,
   input  logic [4:0]  req_entry_index,
   input  logic [39:0] req_entry_color,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_red,
   output logic [7:0]  rsp_green,
   output logic [7:0]  rsp_blue,
   output logic [7:0]  rsp_white,
   output logic [7:0]  rsp_alpha,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);

   localparam int unsigned CW     = $clog2(PALETTE_DEPTH);
   localparam int unsigned CS_W   = CW + 18;
   localparam int unsigned NUM_W  = CW + 34;
   localparam int unsigned DIVD_W = CW + 36;
   localparam int unsigned STG_MAG   = 1;
   localparam int unsigned STG_LANE  = 2;
   localparam int unsigned STG_SUM   = STG_LANE + msp_pkg::LANE_STAGES;
   localparam int unsigned STG_SCALE = STG_SUM + 1;
   localparam int unsigned STG_NUM   = STG_SCALE + 1;
   localparam int unsigned STG_DIVD  = STG_NUM + 1;
   localparam int unsigned STG_DIV   = STG_DIVD + 1;
   localparam int unsigned NST       = STG_DIV + CW;

   logic [15:0] freq_one_ff, freq_two_ff, freq_three_ff, strip_length_ff;
   logic [5:0]  palette_count_ff;

   msp_pkg::ctl_type ctl_ff [NST];
   msp_pkg::ctl_type ctl_in [NST];
   logic [NST-1:0]   en;
   logic             out_en;

   logic [15:0]       len_eff;
   logic [8:0]        cnt9;
   logic [CW-1:0]     cnt_m1;
   logic [33:0]       den;
   logic [62:0]       t_prod;
   logic [25:0]       quo100_ff, quo100_in;
   logic [15:0]       pix0_ff;
   logic signed [26:0] delta;
   logic [25:0]       mag_ff, mag_in;
   logic [15:0]       fade_in;
   logic [15:0]       fade_ff [STG_MAG:STG_SCALE];
   logic [15:0]       wave_one, wave_two, wave_three;
   logic [17:0]       sum_ff;
   logic [CS_W-1:0]   scale_ff;
   logic [NUM_W-1:0]  num_ff;
   logic [DIVD_W-1:0] divd_ff;
   logic [CW-1:0]     quotient;
   logic [39:0]       color;

   always_ff @(posedge clock) begin
      if (reset) begin
         freq_one_ff      <= 16'd4588;
         freq_two_ff      <= 16'd14418;
         freq_three_ff    <= 16'd20316;
         strip_length_ff  <= 16'd144;
         palette_count_ff <= 6'd8;
      end else if (csr_write) begin
         unique case (csr_index)
            msp_pkg::CSR_FREQ_ONE:      freq_one_ff      <= csr_data;
            msp_pkg::CSR_FREQ_TWO:      freq_two_ff      <= csr_data;
            msp_pkg::CSR_FREQ_THREE:    freq_three_ff    <= csr_data;
            msp_pkg::CSR_STRIP_LENGTH:  strip_length_ff  <= csr_data;
            msp_pkg::CSR_PALETTE_COUNT: palette_count_ff <= csr_data[5:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      len_eff = (strip_length_ff == 16'd0) ? 16'd1 : strip_length_ff;
      cnt9    = (palette_count_ff == 6'd0) ? 9'd1 : 9'(palette_count_ff);
      if (cnt9 > 9'(PALETTE_DEPTH)) begin
         cnt9 = 9'(PALETTE_DEPTH);
      end
      cnt_m1 = CW'(cnt9 - 9'd1);
      den    = {18'(len_eff) + {1'b0, len_eff, 1'b0}, 16'd0};
   end

   always_comb begin
      out_en      = !rsp_valid || !rsp_stall;
      en[NST-1]   = !ctl_ff[NST-1].valid || out_en;
      for (int s = int'(NST) - 2; s >= 0; s--) begin
         en[s] = !ctl_ff[s].valid || en[s+1];
      end
   end

   assign req_stall = !en[0];

   always_comb begin
      ctl_in[0].valid = req_valid;
      ctl_in[0].mode  = req_mode;
      ctl_in[0].slot  = req_entry_index;
      ctl_in[0].color = req_entry_color;
      for (int s = 1; s < int'(NST); s++) begin
         ctl_in[s] = ctl_ff[s-1];
      end
   end

   for (genvar s = 0; s < NST; s++) begin : g_ctl
      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[s].valid <= 1'b0;
         end else if (en[s]) begin
            ctl_ff[s] <= ctl_in[s];
         end
      end
   end

   always_comb begin
      t_prod    = 63'(req_time_ms) * 63'(msp_pkg::DIV100_MULT);
      quo100_in = 26'(t_prod >> msp_pkg::DIV100_SHIFT);
      delta     = $signed({11'd0, pix0_ff}) - $signed({1'b0, quo100_ff});
      mag_in    = (delta < 0) ? 26'(-delta) : 26'(delta);
      fade_in   = (pix0_ff < len_eff) ? (len_eff - pix0_ff) : 16'd0;
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         quo100_ff <= quo100_in;
         pix0_ff   <= req_pixel_index;
      end
      if (en[STG_MAG]) begin
         mag_ff           <= mag_in;
         fade_ff[STG_MAG] <= fade_in;
      end
      if (en[STG_SUM]) begin
         sum_ff <= 18'(wave_one) + 18'(wave_two) + 18'(wave_three);
      end
      if (en[STG_SCALE]) begin
         scale_ff <= CS_W'(cnt_m1) * CS_W'(sum_ff);
      end
      if (en[STG_NUM]) begin
         num_ff <= NUM_W'(scale_ff) * NUM_W'(fade_ff[STG_SCALE]);
      end
      if (en[STG_DIVD]) begin
         divd_ff <= DIVD_W'({num_ff, 1'b0}) + DIVD_W'(den);
      end
   end

   for (genvar s = STG_MAG + 1; s <= STG_SCALE; s++) begin : g_fade
      always_ff @(posedge clock) begin
         if (en[s]) begin
            fade_ff[s] <= fade_ff[s-1];
         end
      end
   end

   msp_wave_lane #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_lane_one (
      .clock    (clock),
      .stage_en (en[STG_SUM-1:STG_LANE]),
      .freq     (freq_one_ff),
      .mag      (mag_ff),
      .wave     (wave_one)
   );

   msp_wave_lane #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_lane_two (
      .clock    (clock),
      .stage_en (en[STG_SUM-1:STG_LANE]),
      .freq     (freq_two_ff),
      .mag      (mag_ff),
      .wave     (wave_two)
   );

   msp_wave_lane #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_lane_three (
      .clock    (clock),
      .stage_en (en[STG_SUM-1:STG_LANE]),
      .freq     (freq_three_ff),
      .mag      (mag_ff),
      .wave     (wave_three)
   );

   msp_round_div #(.QUO_W(CW), .NUM_W(DIVD_W), .DEN_W(35)) u_div (
      .clock    (clock),
      .stage_en (en[NST-1:STG_DIV]),
      .dividend (divd_ff),
      .divisor  ({den, 1'b0}),
      .quotient (quotient)
   );

   msp_palette #(.PALETTE_DEPTH(PALETTE_DEPTH)) u_palette (
      .clock        (clock),
      .reset        (reset),
      .advance      (out_en),
      .ctl          (ctl_ff[NST-1]),
      .read_index   (quotient),
      .result_valid (rsp_valid),
      .result_color (color)
   );

   assign rsp_red   = color[39:32];
   assign rsp_green = color[31:24];
   assign rsp_blue  = color[23:16];
   assign rsp_white = color[15:8];
   assign rsp_alpha = color[7:0];

   `MSP_ASSERT(a_write_gives_no_result, clock, reset, (out_en && ctl_ff[NST-1].valid && ctl_ff[NST-1].mode == msp_pkg::MODE_WRITE) |=> !rsp_valid)
   `MSP_ASSERT(a_stall_only_when_full, clock, reset, req_stall |-> ctl_ff[0].valid)
   `MSP_ASSERT_NEVER(a_free_output_never_stalls, clock, reset, !rsp_stall && req_stall)

endmodule
